/* rtl/multi_sensor_overtemp_debounce_defines.svh */
// ---------------------------------------------------------------------------
// Shared assertion macros for the over-temperature debounce block
// Both macros sample on clk_i and hold off while rst_ni is low.
// ---------------------------------------------------------------------------
`ifndef MULTI_SENSOR_OVERTEMP_DEBOUNCE_DEFINES_SVH
`define MULTI_SENSOR_OVERTEMP_DEBOUNCE_DEFINES_SVH

// Same-cycle implication.
`define MSOD_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define MSOD_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* rtl/msod_pkg.sv */
// ---------------------------------------------------------------------------
// msod_pkg
// Types, codes and sizes shared by the over-temperature debounce block.
// ---------------------------------------------------------------------------
package msod_pkg;

  localparam int unsigned MaxSensors = 64;
  localparam int unsigned IdxW       = $clog2(MaxSensors);
  localparam int unsigned CountW     = 7;

  // Fault states
  localparam logic [1:0] StIdle      = 2'd0;
  localparam logic [1:0] StSetting   = 2'd1;
  localparam logic [1:0] StSet       = 2'd2;
  localparam logic [1:0] StReleasing = 2'd3;

  // Event codes
  localparam logic [1:0] EvtNone     = 2'd0;
  localparam logic [1:0] EvtSet      = 2'd1;
  localparam logic [1:0] EvtRelease  = 2'd2;

  // Register indexes
  localparam logic [2:0] RegSetThreshold     = 3'd0;
  localparam logic [2:0] RegSetTime          = 3'd1;
  localparam logic [2:0] RegReleaseThreshold = 3'd2;
  localparam logic [2:0] RegReleaseTime      = 3'd3;
  localparam logic [2:0] RegOverIsLow        = 3'd4;
  localparam logic [2:0] RegSensorCount      = 3'd5;
  localparam logic [2:0] RegLevelId          = 3'd6;

  typedef struct packed {
    logic [15:0]       set_threshold;
    logic [7:0]        set_time;
    logic [15:0]       release_threshold;
    logic [7:0]        release_time;
    logic              over_is_low;
    logic [CountW-1:0] sensor_count;
    logic [1:0]        level_id;
  } cfg_t;

  // Per-sensor stored state
  typedef struct packed {
    logic [1:0] fault_state;
    logic [7:0] set_cnt;
    logic [7:0] rel_cnt;
  } entry_t;

endpackage

/* rtl/msod_ram.sv */
// ---------------------------------------------------------------------------
// msod_ram
// Generic simple dual-port RAM, one write and one registered read port.
// ---------------------------------------------------------------------------
module msod_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

/* rtl/msod_cfg_regs.sv */
// ---------------------------------------------------------------------------
// msod_cfg_regs
// Configuration register file, written one register per transfer.
// ---------------------------------------------------------------------------
module msod_cfg_regs (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_valid_i,
  output logic                cfg_ready_o,
  input  logic [2:0]          cfg_index_i,
  input  logic [15:0]         cfg_data_i,
  output msod_pkg::cfg_t      cfg_o
);

  msod_pkg::cfg_t cfg_q, cfg_d;

  assign cfg_ready_o = 1'b1;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_valid_i) begin
      case (cfg_index_i)
        msod_pkg::RegSetThreshold:     cfg_d.set_threshold     = cfg_data_i;
        msod_pkg::RegSetTime:          cfg_d.set_time          = cfg_data_i[7:0];
        msod_pkg::RegReleaseThreshold: cfg_d.release_threshold = cfg_data_i;
        msod_pkg::RegReleaseTime:      cfg_d.release_time      = cfg_data_i[7:0];
        msod_pkg::RegOverIsLow:        cfg_d.over_is_low       = cfg_data_i[0];
        msod_pkg::RegSensorCount:
          cfg_d.sensor_count = cfg_data_i[msod_pkg::CountW-1:0];
        msod_pkg::RegLevelId:          cfg_d.level_id          = cfg_data_i[1:0];
        default: ;  // drop writes beyond the register list
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.set_threshold     <= 16'd0;
      cfg_q.set_time          <= 8'd3;
      cfg_q.release_threshold <= 16'd0;
      cfg_q.release_time      <= 8'd3;
      cfg_q.over_is_low       <= 1'b1;
      cfg_q.sensor_count      <= msod_pkg::CountW'(1);
      cfg_q.level_id          <= 2'd0;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

/* rtl/msod_step.sv */
// ---------------------------------------------------------------------------
// msod_step
// Next-state logic of one sensor's fault machine and debounce counters.
// ---------------------------------------------------------------------------
module msod_step (
  input  logic [15:0]      sample_i,
  input  msod_pkg::cfg_t   cfg_i,
  input  msod_pkg::entry_t entry_i,
  output msod_pkg::entry_t entry_o,
  output logic [1:0]       event_o
);

  logic       over;
  logic       under;
  logic [7:0] set_inc;
  logic [7:0] rel_inc;
  logic [1:0] st_mid;
  logic [7:0] set_mid;

  always_comb begin
    if (cfg_i.over_is_low) begin
      over  = sample_i <= cfg_i.set_threshold;
      under = sample_i >= cfg_i.release_threshold;
    end else begin
      over  = sample_i >= cfg_i.set_threshold;
      under = sample_i <= cfg_i.release_threshold;
    end
  end

  assign set_inc = entry_i.set_cnt + 8'd1;
  assign rel_inc = entry_i.rel_cnt + 8'd1;

  always_comb begin
    st_mid  = entry_i.fault_state;
    set_mid = entry_i.set_cnt;
    event_o = msod_pkg::EvtNone;
    entry_o = entry_i;

    // over test first, moving toward set
    if (over) begin
      if (entry_i.fault_state == msod_pkg::StIdle) begin
        st_mid  = msod_pkg::StSetting;
        set_mid = 8'd1;
      end else if (entry_i.fault_state == msod_pkg::StSetting) begin
        set_mid = set_inc;
        if (set_inc >= cfg_i.set_time) begin
          st_mid  = msod_pkg::StSet;
          set_mid = 8'd0;
          event_o = msod_pkg::EvtSet;
        end
      end
    end else if (entry_i.fault_state == msod_pkg::StSetting) begin
      st_mid = msod_pkg::StIdle;  // abort pending set
    end

    entry_o.fault_state = st_mid;
    entry_o.set_cnt     = set_mid;

    // release test on the updated state
    if (under) begin
      if (st_mid == msod_pkg::StSet) begin
        entry_o.fault_state = msod_pkg::StReleasing;
        entry_o.rel_cnt     = 8'd1;
      end else if (st_mid == msod_pkg::StReleasing) begin
        entry_o.rel_cnt = rel_inc;
        if (rel_inc >= cfg_i.release_time) begin
          entry_o.fault_state = msod_pkg::StIdle;
          entry_o.rel_cnt     = 8'd0;
          event_o             = msod_pkg::EvtRelease;
        end
      end
    end else if (st_mid == msod_pkg::StReleasing) begin
      entry_o.fault_state = msod_pkg::StSet;  // abort pending release
    end
  end

endmodule

/* rtl/multi_sensor_overtemp_debounce.sv */
// ---------------------------------------------------------------------------
// multi_sensor_overtemp_debounce
// Round-robin thermistor over-temperature debounce with hysteresis.
// ---------------------------------------------------------------------------
// Each sample transfer on the s_axis channel belongs to the sensor at the
// internal round-robin pointer, which wraps at the configured sensor count.
// One result transfer leaves on m_axis per sample: sensor index, fault state,
// event code and level, with tlast marking the sensor that closes a scan.
// Registers are written through the cfg channel (index, data), which is
// always ready; write them only while no sample is in flight.
// A sample is registered in the s1 stage, then stepped and registered in the
// output register. The per-sensor state lives in a 64-entry RAM with a
// registered read, fetched at the sample transfer from the pointer, which is
// known ahead; a result written back in the same cycle is forwarded. One
// sample per cycle, one RAM read-modify-write each, unless m_axis_tready stalls.
// Reset clears the pointer and one valid bit per sensor, so every sensor
// starts idle with zero counters at once; no clearing pass is needed.
// When m_axis_tready stays low, the output register and the stage behind it
// fill and s_axis_tready drops; nothing is lost.
// ---------------------------------------------------------------------------
`include "multi_sensor_overtemp_debounce_defines.svh"

module multi_sensor_overtemp_debounce (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [15:0] s_axis_tdata,   // [15:0] ntc_sample
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [15:0] m_axis_tdata,   // [5:0] sensor_index, [7:6] fault_state,
                                      // [9:8] event_code, [11:10] event_level
  output logic        m_axis_tlast,   // scan_done
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [2:0]  cfg_index_i,
  input  logic [15:0] cfg_data_i
);

  localparam int unsigned IdxW   = msod_pkg::IdxW;
  localparam int unsigned CountW = msod_pkg::CountW;

  msod_pkg::cfg_t   cfg;
  msod_pkg::entry_t ram_rdata;
  msod_pkg::entry_t cur_entry;
  msod_pkg::entry_t new_entry;
  logic [1:0]       new_evt;

  logic                  in_xfer;
  logic                  s1_advance;
  logic [IdxW-1:0]       ptr_q, ptr_d;
  logic [CountW-1:0]     ptr_inc;
  logic [CountW-1:0]     count_lim;
  logic                  wrap;
  logic [msod_pkg::MaxSensors-1:0] valid_q;

  logic                  s1_valid_q;
  logic [15:0]           s1_sample_q;
  logic [IdxW-1:0]       s1_idx_q;
  logic                  s1_done_q;
  logic                  s1_hit_q;
  logic                  fwd_q;
  msod_pkg::entry_t      fwd_entry_q;

  logic                  out_valid_q;
  logic [IdxW-1:0]       out_idx_q;
  logic [1:0]            out_state_q;
  logic [1:0]            out_evt_q;
  logic [1:0]            out_lvl_q;
  logic                  out_done_q;

  msod_cfg_regs u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .cfg_o       (cfg)
  );

  assign s1_advance    = s1_valid_q && (!out_valid_q || m_axis_tready);
  assign s_axis_tready = !s1_valid_q || s1_advance;
  assign in_xfer       = s_axis_tvalid && s_axis_tready;

  // Pointer advance; a count above the sensor total acts as the total
  assign ptr_inc   = CountW'(ptr_q) + CountW'(1);
  assign count_lim = (cfg.sensor_count > CountW'(msod_pkg::MaxSensors))
                     ? CountW'(msod_pkg::MaxSensors) : cfg.sensor_count;
  assign wrap      = ptr_inc >= count_lim;
  assign ptr_d     = wrap ? '0 : ptr_inc[IdxW-1:0];

  msod_ram #(
    .Width ($bits(msod_pkg::entry_t)),
    .Depth (msod_pkg::MaxSensors)
  ) u_state_ram (
    .clk_i   (clk_i),
    .we_i    (s1_advance),
    .waddr_i (s1_idx_q),
    .wdata_i (new_entry),
    .re_i    (in_xfer),
    .raddr_i (ptr_q),
    .rdata_o (ram_rdata)
  );

  // Forwarded write wins, then the RAM word if the sensor was ever written
  always_comb begin
    if (fwd_q) begin
      cur_entry = fwd_entry_q;
    end else if (s1_hit_q) begin
      cur_entry = ram_rdata;
    end else begin
      cur_entry = '0;
    end
  end

  msod_step u_step (
    .sample_i (s1_sample_q),
    .cfg_i    (cfg),
    .entry_i  (cur_entry),
    .entry_o  (new_entry),
    .event_o  (new_evt)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ptr_q       <= '0;
      valid_q     <= '0;
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (in_xfer) begin
        ptr_q <= ptr_d;
      end
      if (s1_advance) begin
        valid_q[s1_idx_q] <= 1'b1;
      end
      if (in_xfer) begin
        s1_valid_q <= 1'b1;
      end else if (s1_advance) begin
        s1_valid_q <= 1'b0;
      end
      if (s1_advance) begin
        out_valid_q <= 1'b1;
      end else if (m_axis_tready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_xfer) begin
      s1_sample_q <= s_axis_tdata;
      s1_idx_q    <= ptr_q;
      s1_done_q   <= wrap;
      s1_hit_q    <= valid_q[ptr_q];
      fwd_q       <= s1_advance && (s1_idx_q == ptr_q);
      fwd_entry_q <= new_entry;
    end
    if (s1_advance) begin
      out_idx_q   <= s1_idx_q;
      out_state_q <= new_entry.fault_state;
      out_evt_q   <= new_evt;
      out_lvl_q   <= (new_evt != msod_pkg::EvtNone) ? cfg.level_id : 2'd0;
      out_done_q  <= s1_done_q;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {4'd0, out_lvl_q, out_evt_q, out_state_q, out_idx_q};
  assign m_axis_tlast  = out_done_q;

  `MSOD_ASSERT_NOW(a_set_evt_state,
    out_valid_q && (out_evt_q == msod_pkg::EvtSet),
    (out_state_q == msod_pkg::StSet) || (out_state_q == msod_pkg::StReleasing),
    "set event without a set or releasing state")
  `MSOD_ASSERT_NOW(a_rel_evt_state,
    out_valid_q && (out_evt_q == msod_pkg::EvtRelease),
    out_state_q == msod_pkg::StIdle,
    "release event without an idle state")
  `MSOD_ASSERT_NOW(a_no_evt_level,
    out_valid_q && (out_evt_q == msod_pkg::EvtNone),
    out_lvl_q == 2'd0,
    "event level reported without an event")
  `MSOD_ASSERT_NEXT(a_writeback_valid,
    s1_advance,
    valid_q[$past(s1_idx_q)],
    "written sensor not marked valid")
  `MSOD_ASSERT_NEXT(a_wrap_done,
    in_xfer && (ptr_d == '0) && (ptr_q != '0),
    s1_done_q,
    "pointer wrap without scan done")

endmodule

/* tb/tb_top.sv */
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// tb_top
// Self-checking bench for the round-robin over-temperature debounce block.
// Samples stream in with random gaps and results drain with random back
// pressure. A scoreboard tracks every sensor's fault state, both debounce
// counters and the scan pointer, predicts each result, and compares it
// field by field. Registers change only while the pipeline is empty.
// ---------------------------------------------------------------------------
import msod_pkg::*;

typedef struct packed {
  logic [5:0] sensor_index;
  logic [1:0] fault_state;
  logic [1:0] event_code;
  logic [1:0] event_level;
  logic       scan_done;
} overtemp_result_t;

class overtemp_scoreboard;
  cfg_t             cfg;
  logic [1:0]       fault_mem[MaxSensors];
  logic [7:0]       set_cnt[MaxSensors];
  logic [7:0]       rel_cnt[MaxSensors];
  logic [5:0]       scan_ptr;
  overtemp_result_t expected_q[$];
  int unsigned      errors;

  function new();
    cfg = '{set_threshold: 16'd0, set_time: 8'd3, release_threshold: 16'd0,
            release_time: 8'd3, over_is_low: 1'b1, sensor_count: 7'd1,
            level_id: 2'd0};
    for (int i = 0; i < MaxSensors; i++) begin
      fault_mem[i] = StIdle;
      set_cnt[i]   = 8'd0;
      rel_cnt[i]   = 8'd0;
    end
    scan_ptr = 6'd0;
    errors   = 0;
  endfunction

  function void note_config(logic [2:0] index, logic [15:0] data);
    case (index)
      RegSetThreshold:     cfg.set_threshold     = data;
      RegSetTime:          cfg.set_time          = data[7:0];
      RegReleaseThreshold: cfg.release_threshold = data;
      RegReleaseTime:      cfg.release_time      = data[7:0];
      RegOverIsLow:        cfg.over_is_low       = data[0];
      RegSensorCount:      cfg.sensor_count      = data[CountW-1:0];
      RegLevelId:          cfg.level_id          = data[1:0];
      default: ;
    endcase
  endfunction

  function void note_sample(logic [15:0] sample);
    overtemp_result_t  r;
    logic [5:0]        idx;
    logic [1:0]        st;
    logic [1:0]        evt;
    logic              over_hit;
    logic              under_hit;
    logic [CountW-1:0] span;

    idx = scan_ptr;
    st  = fault_mem[idx];
    evt = EvtNone;
    if (cfg.over_is_low) begin
      over_hit  = sample <= cfg.set_threshold;
      under_hit = sample >= cfg.release_threshold;
    end else begin
      over_hit  = sample >= cfg.set_threshold;
      under_hit = sample <= cfg.release_threshold;
    end

    // Over test first, then release test on the updated state.
    if (over_hit) begin
      if (st == StIdle) begin
        st = StSetting;
        set_cnt[idx] = 8'd1;
      end else if (st == StSetting) begin
        set_cnt[idx] = set_cnt[idx] + 8'd1;
        if (set_cnt[idx] >= cfg.set_time) begin
          st = StSet;
          set_cnt[idx] = 8'd0;
          evt = EvtSet;
        end
      end
    end else if (st == StSetting) begin
      st = StIdle;
    end

    if (under_hit) begin
      if (st == StSet) begin
        st = StReleasing;
        rel_cnt[idx] = 8'd1;
      end else if (st == StReleasing) begin
        rel_cnt[idx] = rel_cnt[idx] + 8'd1;
        if (rel_cnt[idx] >= cfg.release_time) begin
          st = StIdle;
          rel_cnt[idx] = 8'd0;
          evt = EvtRelease;
        end
      end
    end else if (st == StReleasing) begin
      st = StSet;
    end

    fault_mem[idx] = st;

    span = (cfg.sensor_count > MaxSensors) ? CountW'(MaxSensors) : cfg.sensor_count;
    r.sensor_index = idx;
    r.fault_state  = st;
    r.event_code   = evt;
    r.event_level  = (evt != EvtNone) ? cfg.level_id : 2'd0;
    r.scan_done    = (CountW'(idx) + CountW'(1)) >= span;
    scan_ptr       = r.scan_done ? 6'd0 : idx + 6'd1;
    expected_q.push_back(r);
  endfunction

  function void compare_field(string name, logic [7:0] want, logic [7:0] got);
    if (got !== want) begin
      $display("%0t: %s mismatch, expected %0d actual %0d", $time, name, want, got);
      errors++;
    end
  endfunction

  function void check_result(logic [15:0] data, logic last);
    overtemp_result_t want;
    if (expected_q.size() == 0) begin
      $display("%0t: result with nothing pending, expected none actual tdata=%h tlast=%b",
               $time, data, last);
      errors++;
      return;
    end
    want = expected_q.pop_front();
    compare_field("sensor_index", 8'(want.sensor_index), 8'(data[5:0]));
    compare_field("fault_state",  8'(want.fault_state),  8'(data[7:6]));
    compare_field("event_code",   8'(want.event_code),   8'(data[9:8]));
    compare_field("event_level",  8'(want.event_level),  8'(data[11:10]));
    compare_field("scan_done",    8'(want.scan_done),    8'(last));
  endfunction
endclass

module tb_top;

  localparam int unsigned CycleLimit   = 400000;
  localparam int unsigned SettleCycles = 6;
  localparam int unsigned PhaseItems   = 75;
  localparam int unsigned PhaseCount   = 8;

  typedef enum int {KindOver, KindUnder, KindNoise} sample_kind_e;

  logic        clk_i;
  logic        rst_ni;
  logic        s_axis_tvalid;
  logic        s_axis_tready;
  logic [15:0] s_axis_tdata;
  logic        m_axis_tvalid;
  logic        m_axis_tready;
  logic [15:0] m_axis_tdata;
  logic        m_axis_tlast;
  logic        cfg_valid_i;
  logic        cfg_ready_o;
  logic [2:0]  cfg_index_i;
  logic [15:0] cfg_data_i;

  overtemp_scoreboard sc;
  int unsigned        send_idle_pct;
  int unsigned        recv_idle_pct;
  int unsigned        cycle_count;

  multi_sensor_overtemp_debounce dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i)
  );

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  // Result side: check each transfer, then pick next cycle's ready.
  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      sc.check_result(m_axis_tdata, m_axis_tlast);
    end
    m_axis_tready <= ($urandom_range(99) >= recv_idle_pct);
  end

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CycleLimit) begin
      $display("simulation failed");
      $finish;
    end
  end

  task automatic send_sample(input logic [15:0] value);
    int unsigned gap;
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= value;
    do @(posedge clk_i); while (s_axis_tready !== 1'b1);
    sc.note_sample(value);
    gap = 0;
    while ($urandom_range(99) < send_idle_pct) gap++;
    if (gap != 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
  endtask

  // Drop valid and hold until every pending result has been checked.
  task automatic wait_results_done();
    s_axis_tvalid <= 1'b0;
    while (sc.expected_q.size() != 0) @(posedge clk_i);
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic [2:0] index, input logic [15:0] data);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= index;
    cfg_data_i  <= data;
    do @(posedge clk_i); while (cfg_ready_o !== 1'b1);
    sc.note_config(index, data);
  endtask

  task automatic apply_cfg(input cfg_t c);
    wait_results_done();
    write_reg(RegSetThreshold,     c.set_threshold);
    write_reg(RegSetTime,          16'(c.set_time));
    write_reg(RegReleaseThreshold, c.release_threshold);
    write_reg(RegReleaseTime,      16'(c.release_time));
    write_reg(RegOverIsLow,        16'(c.over_is_low));
    write_reg(RegSensorCount,      16'(c.sensor_count));
    write_reg(RegLevelId,          16'(c.level_id));
    cfg_valid_i <= 1'b0;
  endtask

  function automatic cfg_t make_cfg(logic [15:0] set_thr, logic [7:0] set_t,
                                    logic [15:0] rel_thr, logic [7:0] rel_t,
                                    logic low, logic [CountW-1:0] count,
                                    logic [1:0] level);
    cfg_t c;
    c.set_threshold     = set_thr;
    c.set_time          = set_t;
    c.release_threshold = rel_thr;
    c.release_time      = rel_t;
    c.over_is_low       = low;
    c.sensor_count      = count;
    c.level_id          = level;
    return c;
  endfunction

  function automatic cfg_t random_cfg();
    cfg_t c;
    c.set_threshold     = 16'($urandom_range(16'hFFFF));
    c.release_threshold = 16'($urandom_range(16'hFFFF));
    c.set_time          = ($urandom_range(9) == 0) ? 8'd255 : 8'($urandom_range(5));
    c.release_time      = ($urandom_range(9) == 0) ? 8'd255 : 8'($urandom_range(5));
    c.over_is_low       = 1'($urandom_range(1));
    c.level_id          = 2'($urandom_range(3));
    case ($urandom_range(9))
      0: c.sensor_count = 7'd0;
      1: c.sensor_count = 7'd64;
      2: c.sensor_count = 7'($urandom_range(127, 65));
      3: c.sensor_count = 7'($urandom_range(16, 5));
      default: c.sensor_count = 7'($urandom_range(4, 1));
    endcase
    return c;
  endfunction

  // Draw a sample from the over band, the recovered band, or anywhere.
  function automatic logic [15:0] band_sample(sample_kind_e kind);
    logic [15:0] s_thr;
    logic [15:0] r_thr;
    s_thr = sc.cfg.set_threshold;
    r_thr = sc.cfg.release_threshold;
    case (kind)
      KindOver:  return sc.cfg.over_is_low ? 16'($urandom_range(s_thr, 0))
                                           : 16'($urandom_range(16'hFFFF, s_thr));
      KindUnder: return sc.cfg.over_is_low ? 16'($urandom_range(16'hFFFF, r_thr))
                                           : 16'($urandom_range(r_thr, 0));
      default:   return 16'($urandom_range(16'hFFFF));
    endcase
  endfunction

  initial begin
    sample_kind_e kind;
    int unsigned  run_left;

    sc            = new();
    clk_i         = 1'b0;
    rst_ni        = 1'b0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = 16'd0;
    m_axis_tready = 1'b0;
    cfg_valid_i   = 1'b0;
    cfg_index_i   = RegSetThreshold;
    cfg_data_i    = 16'd0;
    cycle_count   = 0;
    send_idle_pct = 12;
    recv_idle_pct = 51;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Reset settings, field extremes.
    send_sample(16'h0000);
    send_sample(16'hFFFF);
    send_sample(16'h0000);

    // Always over and always recovered: set then releasing in one step,
    // release on the next; zero count pins sensor 0 with scan_done.
    apply_cfg(make_cfg(16'hFFFF, 8'd1, 16'h0000, 8'd1, 1'b1, 7'd0, 2'd3));
    repeat (4) send_sample(16'($urandom_range(16'hFFFF)));

    // High-is-over polarity, zero times, count above the sensor total.
    apply_cfg(make_cfg(16'h8000, 8'd0, 16'h7FFF, 8'd0, 1'b0, 7'd127, 2'd1));
    send_sample(16'hFFFF);
    send_sample(16'h0000);

    // Count lowered under the pointer; inclusive boundaries after that.
    apply_cfg(make_cfg(16'h8000, 8'd0, 16'h7FFF, 8'd0, 1'b0, 7'd1, 2'd2));
    send_sample(16'hFFFF);
    send_sample(16'hFFFF);
    send_sample(16'hFFFF);
    send_sample(16'h0000);
    send_sample(16'h0000);
    send_sample(16'h8000);
    send_sample(16'h7FFF);

    apply_cfg(make_cfg(16'h1000, 8'd2, 16'h2000, 8'd2, 1'b1, 7'd8, 2'd0));
    repeat (5) send_sample(16'($urandom_range(16'h1000)));
    apply_cfg(make_cfg(16'h1000, 8'd2, 16'h2000, 8'd2, 1'b1, 7'd2, 2'd0));
    send_sample(16'h0800);

    for (int ph = 0; ph < PhaseCount; ph++) begin
      if (ph == 3) begin
        send_idle_pct = 51;
        recv_idle_pct = 12;
      end else if (ph == 6) begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end
      if (ph == 0) begin
        apply_cfg(make_cfg(16'hFFFF, 8'd255, 16'hFFFF, 8'd255, 1'b1, 7'd64, 2'd3));
      end else if (ph == 1) begin
        apply_cfg(make_cfg(16'h0000, 8'd0, 16'h0000, 8'd0, 1'b0, 7'd1, 2'd0));
      end else begin
        apply_cfg(random_cfg());
      end
      run_left = 0;
      kind     = KindNoise;
      for (int n = 0; n < PhaseItems; n++) begin
        if (ph == 4 && n == PhaseItems / 2) wait_results_done();
        if (run_left == 0) begin
          kind     = sample_kind_e'($urandom_range(9) < 2 ? KindNoise : $urandom_range(1));
          run_left = $urandom_range(24, 1);
        end
        run_left--;
        send_sample(($urandom_range(99) < 15) ? band_sample(KindNoise) : band_sample(kind));
      end
    end

    wait_results_done();
    if (sc.errors == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
